// ===== hdl/css_pkg.sv =====
// Shared types and constants for the circle scanline span block.
// Holds the controller-to-datapath command and status structs.
// No dependencies.
package css_pkg;

    // Width of every coordinate field on the ports.
    localparam int FIELD_W = 16;

    // Decision variable constants of the midpoint circle walk.
    localparam int D_INIT     = 3;
    localparam int D_INC_NEG  = 6;
    localparam int D_INC_POS  = 10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take a new circle and start the walk
        logic step;     // advance one point along the octant
        logic capture;  // register the result of the walk
    } css_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;  // a has passed b, the octant is exhausted
        logic hit;        // one of the mirrored rows matches the scanline
    } css_status_t;

endpackage

// ===== hdl/css_in_if.sv =====
// Input channel of the circle scanline span block: one circle and a scanline.
// Depends on css_pkg for the field width.
interface css_in_if;
    import css_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] center_x;
    logic [FIELD_W-1:0] center_y;
    logic [FIELD_W-1:0] radius;
    logic [FIELD_W-1:0] line_y;

    modport source (output valid, output center_x, output center_y, output radius,
                    output line_y, input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    input line_y, output ready);
endinterface

// ===== hdl/css_out_if.sv =====
// Output channel of the circle scanline span block: found flag and span ends.
// Depends on css_pkg for the field width.
interface css_out_if;
    import css_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [FIELD_W-1:0] right_x;
    logic [FIELD_W-1:0] left_x;

    modport source (output valid, output found, output right_x, output left_x,
                    input ready);
    modport sink   (input valid, input found, input right_x, input left_x,
                    output ready);
endinterface

// ===== hdl/circle_scanline_span.sv =====
// Top level of the circle scanline span block.
// Depends on css_pkg, css_in_if, css_out_if, css_ctrl and css_datapath.
//
// Usage: each transaction on the circle channel carries a circle (center_x,
// center_y, radius) and a scanline line_y. The block walks one octant of the
// circle with a midpoint decision variable, one point per clock cycle, and
// tests the four mirrored rows of each point against the scanline. Each
// input transaction yields exactly one transaction on the span channel:
// found is set with right_x and left_x on the first matching row, and a
// miss gives found clear with both ends zero. Coordinates wrap modulo
// 2^COORD_BITS; only the low COORD_BITS bits of each field are used.
// The walk stops at the first matching point, or once a has passed b on a
// miss, and the result is then captured into the output register. One item
// is walked at a time: a new circle is taken only after the last walk has
// finished, as the block has a single step unit.
// The result sits in an output register, so the next circle is accepted while
// it waits; if the receiver stalls, a finished walk holds until the register
// frees. Reset clears the controller and drops any pending result.
module circle_scanline_span #(
    parameter int COORD_BITS = 16
) (
    input logic clk,
    input logic rst_n,
    css_in_if.sink    circle,
    css_out_if.source span
);
    import css_pkg::*;

    css_cmd_t    cmd;
    css_status_t status;

    css_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (circle.valid),
        .in_ready  (circle.ready),
        .out_valid (span.valid),
        .out_ready (span.ready),
        .cmd       (cmd),
        .status    (status)
    );

    css_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .center_x (circle.center_x),
        .center_y (circle.center_y),
        .radius   (circle.radius),
        .line_y   (circle.line_y),
        .found    (span.found),
        .right_x  (span.right_x),
        .left_x   (span.left_x)
    );

endmodule

// ===== hdl/css_datapath.sv =====
// Datapath of the circle scanline span block: walk registers, row compares
// and result registers. Depends on css_pkg for commands, status and constants.
module css_datapath #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  css_pkg::css_cmd_t           cmd,
    output css_pkg::css_status_t        status,
    input  logic [css_pkg::FIELD_W-1:0] center_x,
    input  logic [css_pkg::FIELD_W-1:0] center_y,
    input  logic [css_pkg::FIELD_W-1:0] radius,
    input  logic [css_pkg::FIELD_W-1:0] line_y,
    output logic                        found,
    output logic [css_pkg::FIELD_W-1:0] right_x,
    output logic [css_pkg::FIELD_W-1:0] left_x
);
    import css_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 5;

    logic [CW-1:0]        cx_reg, cy_reg, ly_reg;
    logic [AW-1:0]        a_reg, a_next, b_reg, b_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        right_reg, right_next, left_reg, left_next;

    logic [CW-1:0]        ua, ub, off;
    logic                 hit_b_lo, hit_a_lo, hit_a_hi, hit_b_hi;
    logic                 walk_done;
    logic [AW-1:0]        a_inc;
    logic signed [DW-1:0] a_s, b_s, r_s;

    assign ua = a_reg[CW-1:0];
    assign ub = b_reg[CW-1:0];

    // The four mirrored rows, tested in the order top, upper, lower, bottom.
    assign hit_b_lo = ((cy_reg - ub) == ly_reg);
    assign hit_a_lo = ((cy_reg - ua) == ly_reg);
    assign hit_a_hi = ((cy_reg + ua) == ly_reg);
    assign hit_b_hi = ((cy_reg + ub) == ly_reg);

    // A zero radius steps b below zero, so the compare is signed.
    assign walk_done        = ($signed(a_reg) > $signed(b_reg));
    assign status.walk_done = walk_done;
    assign status.hit       = !walk_done && (hit_b_lo || hit_a_lo || hit_a_hi || hit_b_hi);

    // Rows at +/- b give offset a; rows at +/- a give offset b.
    always_comb
    begin
        if (hit_b_lo)
        begin
            off = ua;
        end
        else if (hit_a_lo || hit_a_hi)
        begin
            off = ub;
        end
        else
        begin
            off = ua;
        end
    end

    assign a_inc = a_reg + AW'(1);
    assign a_s   = signed'(DW'(a_inc));
    assign b_s   = signed'(DW'(b_reg));
    assign r_s   = signed'(DW'(radius[CW-1:0]));

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        found_next = found_reg;
        right_next = right_reg;
        left_next  = left_reg;
        if (cmd.load)
        begin
            a_next = '0;
            b_next = AW'(radius[CW-1:0]);
            d_next = DW'(D_INIT) - (r_s <<< 1);
        end
        else if (cmd.step)
        begin
            a_next = a_inc;
            if (d_reg < 0)
            begin
                d_next = d_reg + (a_s <<< 2) + DW'(D_INC_NEG);
            end
            else
            begin
                d_next = d_reg + DW'(D_INC_POS) + ((a_s - b_s) <<< 2);
                b_next = b_reg - AW'(1);
            end
        end
        if (cmd.capture)
        begin
            found_next = status.hit;
            right_next = status.hit ? (cx_reg + off) : '0;
            left_next  = status.hit ? (cx_reg - off) : '0;
        end
    end

    // Walk and result registers; the controller owns all control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            ly_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            d_reg     <= '0;
            found_reg <= 1'b0;
            right_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                cx_reg <= center_x[CW-1:0];
                cy_reg <= center_y[CW-1:0];
                ly_reg <= line_y[CW-1:0];
            end
            a_reg     <= a_next;
            b_reg     <= b_next;
            d_reg     <= d_next;
            found_reg <= found_next;
            right_reg <= right_next;
            left_reg  <= left_next;
        end
    end

    assign found   = found_reg;
    assign right_x = FIELD_W'(right_reg);
    assign left_x  = FIELD_W'(left_reg);

endmodule

// ===== hdl/css_ctrl.sv =====
// Controller of the circle scanline span block: input and output handshakes
// and sequencing of the walk. Depends on css_pkg for command and status.
module css_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output css_pkg::css_cmd_t    cmd,
    input  css_pkg::css_status_t status
);
    import css_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept, slot_free, finish;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == ST_WALK) && (status.walk_done || status.hit)
                       && slot_free;

    assign cmd.load    = accept;
    assign cmd.step    = (state_reg == ST_WALK) && !status.walk_done && !status.hit;
    assign cmd.capture = finish;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== tb/tb_circle_scanline_span.sv =====
// Self-checking testbench for circle_scanline_span: directed table, then random circles.
// Each result is checked against a typed-in value or a midpoint-circle octant walk modeled in this file.
// Depends on css_pkg, css_in_if, css_out_if and the circle_scanline_span RTL.
module tb_circle_scanline_span;
    timeunit 1ns;
    timeprecision 1ps;

    import css_pkg::*;

    localparam int COORD_BITS   = 16;
    localparam int NUM_RANDOM   = 1130;
    localparam int SETTLE_TICKS = 20;

    // One span transaction as the block reports it.
    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] right_x;
        logic [FIELD_W-1:0] left_x;
    } span_t;

    // One circle transaction. When fixed is set, the row carries a result that
    // can be read straight off the geometry, and that value is checked instead
    // of the walk model.
    typedef struct packed {
        logic [FIELD_W-1:0] cx;
        logic [FIELD_W-1:0] cy;
        logic [FIELD_W-1:0] r;
        logic [FIELD_W-1:0] ly;
        logic               fixed;
        span_t              want;
    } probe_t;

    localparam span_t NO_SPAN = '{found: 1'b0, right_x: '0, left_x: '0};
    localparam span_t MODELED = NO_SPAN;

    // Directed stimulus. Rows that hit at the first point of the walk or miss
    // outright have their answer typed in; the rest go through the model.
    localparam int NUM_DIRECTED = 22;
    localparam probe_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // Zero radius: only the center row can match.
        '{16'd1000,  16'd2000,  16'd0,     16'd2000,  1'b1, '{1'b1, 16'd1000, 16'd1000}},
        '{16'd1000,  16'd2000,  16'd0,     16'd2001,  1'b1, NO_SPAN},
        '{16'd0,     16'd0,     16'd0,     16'd0,     1'b1, '{1'b1, 16'd0, 16'd0}},
        // Center and radius at their maximum: cy - r lands on row 0.
        '{16'd65535, 16'd65535, 16'd65535, 16'd0,     1'b1, '{1'b1, 16'd65535, 16'd65535}},
        // Top and bottom rows of a small circle hit at offset zero.
        '{16'd100,   16'd200,   16'd10,    16'd190,   1'b1, '{1'b1, 16'd100, 16'd100}},
        '{16'd100,   16'd200,   16'd10,    16'd210,   1'b1, '{1'b1, 16'd100, 16'd100}},
        // The center row gives the full diameter.
        '{16'd100,   16'd200,   16'd10,    16'd200,   1'b1, '{1'b1, 16'd110, 16'd90}},
        // One row past the bottom edge misses.
        '{16'd100,   16'd200,   16'd10,    16'd211,   1'b1, NO_SPAN},
        '{16'd100,   16'd200,   16'd10,    16'd195,   1'b0, MODELED},
        '{16'd100,   16'd200,   16'd10,    16'd205,   1'b0, MODELED},
        '{16'd100,   16'd200,   16'd10,    16'd193,   1'b0, MODELED},
        // Rows wrapping past the top and past the bottom of the coordinate range.
        '{16'd5,     16'd3,     16'd10,    16'd65529, 1'b1, '{1'b1, 16'd5, 16'd5}},
        '{16'd65535, 16'd65530, 16'd20,    16'd14,    1'b1, '{1'b1, 16'd65535, 16'd65535}},
        // Span ends wrapping on the right and on the left.
        '{16'd65530, 16'd500,   16'd20,    16'd500,   1'b1, '{1'b1, 16'd14, 16'd65510}},
        '{16'd3,     16'd40,    16'd9,     16'd40,    1'b1, '{1'b1, 16'd12, 16'd65530}},
        // Full radius: the match lies deep in the octant.
        '{16'd4321,  16'd32768, 16'd65535, 16'd0,     1'b0, MODELED},
        // Long walk that ends in a miss: the scanline is half the range away.
        '{16'd1234,  16'd100,   16'd30000, 16'd32868, 1'b1, NO_SPAN},
        '{16'd10,    16'd10,    16'd1,     16'd11,    1'b0, MODELED},
        '{16'd10,    16'd10,    16'd2,     16'd9,     1'b0, MODELED},
        '{16'd65535, 16'd65535, 16'd3,     16'd65535, 1'b1, '{1'b1, 16'd2, 16'd65532}},
        '{16'd32768, 16'd0,     16'd32768, 16'd32768, 1'b1, '{1'b1, 16'd32768, 16'd32768}},
        '{16'd777,   16'd1000,  16'd255,   16'd1180,  1'b0, MODELED}
    };

    logic clk = 1'b0;
    logic rst_n;

    css_in_if  circle_if ();
    css_out_if span_if ();

    circle_scanline_span #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .circle (circle_if),
        .span   (span_if)
    );

    // Spans still owed by the block, oldest first.
    span_t pending_spans [$];

    int  mismatches   = 0;
    int  spans_seen   = 0;
    int  spans_found  = 0;
    int  widest_r     = 0;
    bit  feed_done    = 1'b0;

    always #5 clk = ~clk;

    // Midpoint circle walk over one octant. At each point (a, b) the rows
    // cy - b, cy - a, cy + a and cy + b are tried in that order; the first
    // match decides the half-width of the span. The decision variable is
    // updated after a has been incremented, which is what the hardware does.
    function automatic span_t walk_octant(input logic [FIELD_W-1:0] cx,
                                          input logic [FIELD_W-1:0] cy,
                                          input logic [FIELD_W-1:0] r,
                                          input logic [FIELD_W-1:0] ly);
        logic [FIELD_W-1:0] mask;
        logic [FIELD_W-1:0] xc;
        logic [FIELD_W-1:0] yc;
        logic [FIELD_W-1:0] yl;
        logic [FIELD_W-1:0] ua;
        logic [FIELD_W-1:0] ub;
        logic [FIELD_W-1:0] off;
        longint             a;
        longint             b;
        longint             d;
        bit                 hit;
        span_t              res;
        mask = FIELD_W'((64'd1 << COORD_BITS) - 64'd1);
        xc   = cx & mask;
        yc   = cy & mask;
        yl   = ly & mask;
        a    = 0;
        b    = longint'(r & mask);
        d    = D_INIT - 2 * b;
        hit  = 1'b0;
        off  = '0;
        while (a <= b && !hit) begin
            ua = FIELD_W'(a) & mask;
            ub = FIELD_W'(b) & mask;
            if (((yc - ub) & mask) == yl) begin
                hit = 1'b1;
                off = ua;
            end else if (((yc - ua) & mask) == yl) begin
                hit = 1'b1;
                off = ub;
            end else if (((yc + ua) & mask) == yl) begin
                hit = 1'b1;
                off = ub;
            end else if (((yc + ub) & mask) == yl) begin
                hit = 1'b1;
                off = ua;
            end else begin
                a++;
                if (d < 0) begin
                    d += 4 * a + D_INC_NEG;
                end else begin
                    d += D_INC_POS + 4 * (a - b);
                    b--;
                end
            end
        end
        res = NO_SPAN;
        if (hit) begin
            res.found   = 1'b1;
            res.right_x = (xc + off) & mask;
            res.left_x  = (xc - off) & mask;
        end
        return res;
    endfunction

    // Reset is held at the start of the run and never asserted again.
    initial begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Circle source. The directed table goes first, then random circles.
    // Each transaction is preceded by a random gap with valid low, except in
    // calm windows where circles are offered back to back. The expectation is
    // queued at the edge where the transaction is accepted.
    initial begin : feed_circles
        probe_t row;
        int     n;
        int     gap;
        int     sel;
        int     reach;
        int     offset;
        bit     calm;
        circle_if.valid    = 1'b0;
        circle_if.center_x = '0;
        circle_if.center_y = '0;
        circle_if.radius   = '0;
        circle_if.line_y   = '0;
        do @(posedge clk); while (!rst_n);
        for (n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
            if (n < NUM_DIRECTED) begin
                row = DIRECTED_ROWS[n];
            end else begin
                row = '0;
                row.cx = FIELD_W'($urandom);
                row.cy = FIELD_W'($urandom);
                // Most circles are display sized so the walk stays short; about
                // one in 128 gets a radius from the whole field range.
                sel = $urandom_range(0, 255);
                if (sel < 2)
                    row.r = FIELD_W'($urandom);
                else if (sel < 64)
                    row.r = FIELD_W'($urandom_range(64, 600));
                else
                    row.r = FIELD_W'($urandom_range(0, 63));
                // Aim most scanlines at the circle's band, up to two rows past its
                // edges included; the rest land anywhere.
                sel = $urandom_range(0, 9);
                if (sel < 8) begin
                    reach  = int'(row.r) + 2;
                    offset = $urandom_range(0, 2 * reach) - reach;
                    row.ly = row.cy + FIELD_W'(offset);
                end else begin
                    row.ly = FIELD_W'($urandom);
                end
            end
            calm = ((n / 50) % 4) == 3;
            gap  = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                circle_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            circle_if.valid    <= 1'b1;
            circle_if.center_x <= row.cx;
            circle_if.center_y <= row.cy;
            circle_if.radius   <= row.r;
            circle_if.line_y   <= row.ly;
            do @(posedge clk); while (!circle_if.ready);
            if (row.fixed)
                pending_spans.push_back(row.want);
            else
                pending_spans.push_back(walk_octant(row.cx, row.cy, row.r, row.ly));
            if (int'(row.r) > widest_r)
                widest_r = int'(row.r);
        end
        circle_if.valid <= 1'b0;
        feed_done = 1'b1;
    end

    // Span sink. Before each transaction ready is dropped for a random stall,
    // with windows where it never drops, so stalls land on every phase of a
    // walk and on a result that is waiting in the output register.
    initial begin : drain_spans
        int k;
        int stall;
        span_if.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        k = 0;
        forever begin
            stall = (((k / 40) % 4) == 1) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                span_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            span_if.ready <= 1'b1;
            do @(posedge clk); while (!span_if.valid);
            k++;
        end
    end

    // Span checker: every accepted transaction is matched against the oldest
    // expectation, field by field.
    always @(posedge clk) begin
        span_t want;
        span_t got;
        if (rst_n && span_if.valid && span_if.ready) begin
            got.found   = span_if.found;
            got.right_x = span_if.right_x;
            got.left_x  = span_if.left_x;
            spans_seen++;
            if (got.found)
                spans_found++;
            if (pending_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("span %0d arrived with nothing expected: found=%0b right=%0d left=%0d",
                             spans_seen, got.found, got.right_x, got.left_x);
            end else begin
                want = pending_spans.pop_front();
                if (got.found !== want.found || got.right_x !== want.right_x ||
                    got.left_x !== want.left_x) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"span %0d mismatch: expected found=%0b right=%0d left=%0d, ",
                                  "got found=%0b right=%0d left=%0d"},
                                 spans_seen, want.found, want.right_x, want.left_x,
                                 got.found, got.right_x, got.left_x);
                end
            end
        end
    end

    // End of run: all circles sent, every expected span drained, then a short
    // quiet period to catch any stray transaction.
    initial begin : finish_run
        wait (feed_done);
        while (pending_spans.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        $display("Checked %0d spans (%0d directed circles), %0d hits and %0d misses.",
                 spans_seen, NUM_DIRECTED, spans_found, spans_seen - spans_found);
        $display("Radii reached up to %0d; %0d mismatches counted.", widest_r, mismatches);
        if (mismatches == 0 && pending_spans.size() == 0)
            $display("tb_circle_scanline_span: done, clean");
        else
            $display("tb_circle_scanline_span: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, so a hang ends as a failure.
    initial begin : watchdog
        #(64'd50_000_000);
        $display("Timed out with %0d spans still expected.", pending_spans.size());
        $display("tb_circle_scanline_span: done, errors");
        $finish;
    end

endmodule

// ===== circle_scanline_span.f =====
hdl/css_pkg.sv
hdl/css_in_if.sv
hdl/css_out_if.sv
hdl/css_datapath.sv
hdl/css_ctrl.sv
hdl/circle_scanline_span.sv
tb/tb_circle_scanline_span.sv
